FILE: rtl/dlr_pkg.sv
// dlr_pkg: shared constants, types and register codes of the DDA line rasterizer.
// No dependencies; compiled first.
`default_nettype none

package dlr_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int ROW_BYTES_W = 16;
  localparam int BPP_W       = 4;
  localparam int COLOR_W     = 32;
  localparam int OFFSET_W    = 26;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 2;

  localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = 16'd4000;
  localparam logic [BPP_W-1:0]       BPP_RST       = 4'd4;
  localparam logic [COLOR_W-1:0]     COLOR_RST     = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BPP       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR     = 2'd2;

  // input action codes
  localparam logic ACT_CLICK = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_COL,
    ST_DIV_ROW
  } state_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/dlr_if.sv
// dlr_if: valid/ready channel interfaces for point requests and pixel results.
// Depends on dlr_pkg.
`default_nettype none

interface dlr_in_if import dlr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;

  modport source (output valid, action, pos_x, pos_y, input ready);
  modport sink   (input valid, action, pos_x, pos_y, output ready);
endinterface

interface dlr_out_if import dlr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pix_x;
  logic [COORD_BITS-1:0] pix_y;
  logic [OFFSET_W-1:0]   byte_offset;
  logic [COLOR_W-1:0]    color;
  logic                  last_pixel;

  modport source (output valid, pix_x, pix_y, byte_offset, color, last_pixel, input ready);
  modport sink   (input valid, pix_x, pix_y, byte_offset, color, last_pixel, output ready);
endinterface

`default_nettype wire

FILE: rtl/dlr_div.sv
// dlr_div: shared restoring divider, one quotient bit per cycle.
// Computes floor(mag * 2^FRAC_BITS / steps) for mag <= steps. Depends on dlr_pkg.
`default_nettype none

module dlr_div import dlr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] mag,
  input  logic [COORD_BITS-1:0] steps,
  output div_stat_t             stat,
  output logic [FRAC_BITS:0]    quot
);

  localparam int CntW = $clog2(FRAC_BITS + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CntW-1:0]       cnt_r, cnt_nxt;
  logic [COORD_BITS-1:0] rem_r, rem_nxt;
  logic [COORD_BITS-1:0] dvs_r, dvs_nxt;
  logic [FRAC_BITS:0]    quot_r, quot_nxt;

  logic [COORD_BITS:0]   shifted;
  logic [COORD_BITS:0]   diff;
  logic                  ge;
  logic                  init_ge;

  assign shifted = {rem_r, 1'b0};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = (shifted >= {1'b0, dvs_r});
  assign init_ge = (mag >= steps);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quot_nxt = quot_r;
    if (start) begin
      // integer bit first: quotient is at most one
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(FRAC_BITS);
      dvs_nxt  = steps;
      rem_nxt  = init_ge ? (mag - steps) : mag;
      quot_nxt = {{FRAC_BITS{1'b0}}, init_ge};
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
      quot_nxt = {quot_r[FRAC_BITS-1:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    quot_r <= quot_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quot_r;

endmodule

`default_nettype wire

FILE: rtl/dda_line_rasterizer.sv
// dda_line_rasterizer: top level, click pairing, per-line setup sequencer and pixel stepper.
// Depends on dlr_pkg, dlr_if (dlr_in_if, dlr_out_if) and dlr_div.
`default_nettype none

// Point requests come in on in_chan: action 0 is a clicked point, action 1 a tick.
// The first click is stored, the second starts a line from it; clicks while a line
// is being drawn are dropped. Line setup runs the shared divider twice (column, then
// row increment), one quotient bit per cycle, with in_ready held low until both divisions
// are done. A tick during a line yields one pixel on out_chan, one per cycle as long as
// the sink keeps out_chan.ready high, with the output register letting the next
// request in while the current pixel is being taken. The line has steps+1 pixels,
// steps = max(|dx|,|dy|); equal endpoints give a single pixel. Ticks while idle give
// nothing. The byte offset is y*row_bytes + x*bytes_per_pixel modulo 2^26. Configuration
// (cfg_index 0 row_bytes, 1 bytes_per_pixel, 2 pixel_color) is to be written by the user
// only while idle; the block itself does not enforce this.

module dda_line_rasterizer import dlr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dlr_in_if.sink                in_chan,
  dlr_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PosW  = COORD_BITS + FRAC_BITS;  // fixed-point position
  localparam int IncW  = FRAC_BITS + 2;           // signed increment, |inc| <= 1.0
  localparam int ProdW = COORD_BITS + ROW_BYTES_W + 1;
  localparam int SumW  = (ProdW > OFFSET_W) ? ProdW : OFFSET_W;

  // ---------------------------------------------------------------- config
  logic [ROW_BYTES_W-1:0] row_bytes_r;
  logic [BPP_W-1:0]       bpp_r;
  logic [COLOR_W-1:0]     color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= ROW_BYTES_RST;
      bpp_r       <= BPP_RST;
      color_r     <= COLOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_BYTES: row_bytes_r <= cfg_wdata[ROW_BYTES_W-1:0];
        CFG_BPP:       bpp_r       <= cfg_wdata[BPP_W-1:0];
        CFG_COLOR:     color_r     <= cfg_wdata[COLOR_W-1:0];
        default:       ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- state
  state_t                state_r, state_nxt;
  logic                  have_start_r;
  logic [COORD_BITS-1:0] start_col_r, start_row_r;
  logic                  line_active_r;
  logic [PosW-1:0]       cur_col_r, cur_row_r;
  logic [IncW-1:0]       inc_col_r, inc_row_r;
  logic [COORD_BITS:0]   left_r;        // pixels still to emit, up to 2^COORD_BITS
  logic [COORD_BITS-1:0] steps_r;
  logic [COORD_BITS-1:0] ady_r;
  logic                  dx_neg_r, dy_neg_r;

  logic                  out_valid_r;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;
  logic [OFFSET_W-1:0]   out_off_r;
  logic [COLOR_W-1:0]    out_color_r;
  logic                  out_last_r;

  // ---------------------------------------------------------------- request decode
  logic in_ready;
  logic in_fire;
  logic click_fire;
  logic tick_fire;
  logic store_first;
  logic line_go;

  assign in_ready    = (state_r == ST_IDLE) && (!out_valid_r || out_chan.ready);
  assign in_fire     = in_chan.valid && in_ready;
  assign click_fire  = in_fire && (in_chan.action == ACT_CLICK) && !line_active_r;
  assign tick_fire   = in_fire && (in_chan.action == ACT_TICK) && line_active_r;
  assign store_first = click_fire && !have_start_r;
  assign line_go     = click_fire && have_start_r;

  // deltas against the stored point
  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS:0]        adx_w, ady_w;
  logic [COORD_BITS-1:0]      adx, ady, steps;

  assign dx    = $signed({1'b0, in_chan.pos_x}) - $signed({1'b0, start_col_r});
  assign dy    = $signed({1'b0, in_chan.pos_y}) - $signed({1'b0, start_row_r});
  assign adx_w = dx[COORD_BITS] ? -dx : dx;
  assign ady_w = dy[COORD_BITS] ? -dy : dy;
  assign adx   = adx_w[COORD_BITS-1:0];
  assign ady   = ady_w[COORD_BITS-1:0];
  assign steps = (adx > ady) ? adx : ady;

  // ---------------------------------------------------------------- shared divider
  div_stat_t             div_stat;
  logic                  div_start;
  logic [COORD_BITS-1:0] div_mag;
  logic [COORD_BITS-1:0] div_steps;
  logic [FRAC_BITS:0]    div_quot;

  dlr_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mag   (div_mag),
    .steps (div_steps),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // quotient to signed increment; zero-length line steps by nothing
  logic [IncW-1:0] quot_ext;
  logic [IncW-1:0] inc_pos, inc_neg;
  assign quot_ext = {1'b0, div_quot};
  assign inc_pos  = (steps_r == '0) ? '0 : quot_ext;
  assign inc_neg  = -inc_pos;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (line_go)       state_nxt = ST_DIV_COL;
      ST_DIV_COL: if (div_stat.done) state_nxt = ST_DIV_ROW;
      ST_DIV_ROW: if (div_stat.done) state_nxt = ST_IDLE;
      default:                       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_mag   = ady_r;
    div_steps = steps_r;
    unique case (state_r)
      ST_IDLE: begin
        div_start = line_go;
        div_mag   = adx;
        div_steps = steps;
      end
      ST_DIV_COL: div_start = div_stat.done;
      ST_DIV_ROW: ;
      default:    ;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  logic [COORD_BITS-1:0] cur_x, cur_y;
  logic [SumW-1:0]       off_full;
  logic                  is_last;

  assign cur_x    = cur_col_r[FRAC_BITS +: COORD_BITS];
  assign cur_y    = cur_row_r[FRAC_BITS +: COORD_BITS];
  assign off_full = SumW'(cur_y) * SumW'(row_bytes_r) + SumW'(cur_x) * SumW'(bpp_r);
  assign is_last  = (left_r <= (COORD_BITS+1)'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      have_start_r  <= 1'b0;
      line_active_r <= 1'b0;
      left_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (store_first) begin
        have_start_r <= 1'b1;
      end else if (line_go) begin
        have_start_r <= 1'b0;
      end

      if (state_r == ST_DIV_ROW && div_stat.done) begin
        line_active_r <= 1'b1;
        left_r        <= {1'b0, steps_r} + 1'b1;
      end else if (tick_fire) begin
        if (is_last) begin
          line_active_r <= 1'b0;
          left_r        <= '0;
        end else begin
          left_r <= left_r - 1'b1;
        end
      end

      if (tick_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end

    // payload registers, no reset
    if (store_first) begin
      start_col_r <= in_chan.pos_x;
      start_row_r <= in_chan.pos_y;
    end

    if (line_go) begin
      steps_r   <= steps;
      ady_r     <= ady;
      dx_neg_r  <= dx[COORD_BITS];
      dy_neg_r  <= dy[COORD_BITS];
      cur_col_r <= {start_col_r, {FRAC_BITS{1'b0}}};
      cur_row_r <= {start_row_r, {FRAC_BITS{1'b0}}};
    end else if (tick_fire) begin
      // increments sign-extended to the position width; wraps harmlessly past the end
      cur_col_r <= cur_col_r + {{(PosW-IncW){inc_col_r[IncW-1]}}, inc_col_r};
      cur_row_r <= cur_row_r + {{(PosW-IncW){inc_row_r[IncW-1]}}, inc_row_r};
    end

    if (state_r == ST_DIV_COL && div_stat.done) begin
      inc_col_r <= dx_neg_r ? inc_neg : inc_pos;
    end
    if (state_r == ST_DIV_ROW && div_stat.done) begin
      inc_row_r <= dy_neg_r ? inc_neg : inc_pos;
    end

    if (tick_fire) begin
      out_x_r     <= cur_x;
      out_y_r     <= cur_y;
      out_off_r   <= off_full[OFFSET_W-1:0];
      out_color_r <= color_r;
      out_last_r  <= is_last;
    end
  end

  // ---------------------------------------------------------------- ports
  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.pix_x       = out_x_r;
  assign out_chan.pix_y       = out_y_r;
  assign out_chan.byte_offset = out_off_r;
  assign out_chan.color       = out_color_r;
  assign out_chan.last_pixel  = out_last_r;

  // ---------------------------------------------------------------- assertions
  // no pixels while the increments are still being set up
  a_no_line_in_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !line_active_r)
    else $error("line active during increment setup");

  // an active line always has pixels left
  a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_active_r |-> (left_r != '0))
    else $error("active line with no pixels left");

  // a line ends only by emitting its last pixel
  a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(line_active_r)) |-> (out_valid_r && out_last_r))
    else $error("line ended without a last pixel");

  // the divider only runs under the setup sequencer
  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (div_stat.busy || div_stat.done) |-> (state_r == ST_DIV_COL || state_r == ST_DIV_ROW))
    else $error("divider active outside setup");

endmodule

`default_nettype wire
